// ----- rtl/crc32c_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_pkg: shared types and functions for the CRC-32C checksum block
// Holds the polynomial, the queue sizing, the word that moves from the front
// end to the back end, and the byte-wise remainder update functions.
// ----------------------------------------------------------------------------
package crc32c_pkg;

	localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_ZERO  = 32'h0000_0000;
	localparam logic [7:0]  BYTE_MASK = 8'hFF;

	// Byte lanes in one data word.
	localparam int MAX_BYTES = 8;

	// Queue between front and back end; depth must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One classified word as handed from the front end to the back end.
	typedef struct packed {
		logic [31:0] data_rem;   // CRC contribution of the data bytes alone
		logic [3:0]  count;      // saturated byte count
		logic        has_bytes;  // count is not zero
		logic        first;
		logic        last;
	} crc_item_t;

	// Fold one byte into a reflected CRC-32C remainder.
	function automatic logic [31:0] crc_byte(input logic [31:0] rem, input logic [7:0] b);
		logic [31:0] r;
		r = rem ^ {24'd0, b & BYTE_MASK};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : CRC_ZERO);
		end
		return r;
	endfunction

	// Advance a remainder over n zero bytes.
	function automatic logic [31:0] crc_zero_adv(input logic [31:0] rem, input logic [3:0] n);
		logic [31:0] r;
		r = rem;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (4'(i) < n) begin
				r = crc_byte(r, 8'h00);
			end
		end
		return r;
	endfunction

	// CRC of the low n bytes of a word, starting from a zero remainder.
	function automatic logic [31:0] crc_data(input logic [63:0] data, input logic [3:0] n);
		logic [31:0] r;
		r = CRC_ZERO;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (4'(i) < n) begin
				r = crc_byte(r, data[8*i +: 8]);
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/crc32c_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_front: input stage of the CRC-32C block
// Accepts a word, saturates its byte count and folds its data bytes into a
// remainder of their own, then hands the classified word to the queue.
// ----------------------------------------------------------------------------
module crc32c_front
	import crc32c_pkg::*;
#(
	parameter int BYTES_PER_WORD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_word,
	input  logic        last_word,
	output logic        push_valid,
	input  logic        push_stall,
	output crc_item_t   push_item
);

	localparam int LIMIT = (BYTES_PER_WORD < MAX_BYTES) ? BYTES_PER_WORD : MAX_BYTES;

	logic       advance;
	logic [3:0] count_sat;
	crc_item_t  item_next;
	logic       valid_s1;
	crc_item_t  item_s1;

	assign advance    = !valid_s1 || !push_stall;
	assign word_stall = !advance;

	always_comb begin
		count_sat           = (byte_count > 4'(LIMIT)) ? 4'(LIMIT) : byte_count;
		item_next.count     = count_sat;
		item_next.has_bytes = (count_sat != 4'd0);
		item_next.first     = first_word;
		item_next.last      = last_word;
		item_next.data_rem  = crc_data(data_word, count_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_valid) begin
			item_s1 <= item_next;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// ----- rtl/crc32c_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_queue: short word queue between front and back end
// Small circular buffer; the head is visible at the pop side without delay.
// ----------------------------------------------------------------------------
module crc32c_queue
	import crc32c_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_stall,
	input  crc_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_stall,
	output crc_item_t pop_item
);

	crc_item_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/crc32c_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_back: remainder update and result register of the CRC-32C block
// Advances the running remainder over the word's byte count, XORs in the
// data contribution, and on a last word loads the checksum register.
// ----------------------------------------------------------------------------
module crc32c_back
	import crc32c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_stall,
	input  crc_item_t   pop_item,
	output logic        checksum_valid,
	input  logic        checksum_stall,
	output logic [31:0] checksum
);

	logic [31:0] rem_q;
	logic        any_q;
	logic        out_valid_q;
	logic [31:0] checksum_q;
	logic [31:0] rem_base;
	logic        any_base;
	logic [31:0] rem_next;
	logic        any_next;
	logic        pop;
	logic        out_take;

	assign out_take  = out_valid_q && !checksum_stall;
	// Only a last word needs the result register; others flow past a stall.
	assign pop_stall = pop_item.last && out_valid_q && checksum_stall;
	assign pop       = pop_valid && !pop_stall;

	always_comb begin
		rem_base = pop_item.first ? CRC_ONES : rem_q;
		any_base = pop_item.first ? 1'b0 : any_q;
		rem_next = crc_zero_adv(rem_base, pop_item.count) ^ pop_item.data_rem;
		any_next = any_base || pop_item.has_bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= CRC_ONES;
			any_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (pop_item.last) begin
					rem_q       <= CRC_ONES;
					any_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					rem_q <= rem_next;
					any_q <= any_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.last) begin
			checksum_q <= any_next ? (rem_next ^ CRC_ONES) : CRC_ZERO;
		end
	end

	assign checksum_valid = out_valid_q;
	assign checksum       = checksum_q;

endmodule

// ----- rtl/crc32c_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_checksum: CRC-32C (Castagnoli) checksum over a word stream
// Inline checksum engine taking one 64-bit word per cycle when not stalled and
// giving one 32-bit checksum at the end of each message.
// ----------------------------------------------------------------------------
// Feed a message as 64-bit words, each carrying 0 to 8 bytes packed from bit 0
// up (first byte in bits 7:0), with byte_count naming how many are valid; a
// count above BYTES_PER_WORD or above 8 saturates to the smaller. first_word
// restarts the remainder at all ones; last_word closes the message and yields
// one checksum (remainder XOR all ones, reflected polynomial 0x82F63B78), or
// zero when the message held no bytes. After a last word the next word always
// opens a new message. The block sustains one word per clock while no stall
// backs up to the input: the front end folds the word's data bytes into a
// standalone remainder, and the only feedback loop, in the back end,
// advances the running remainder over the byte count and XORs that in
// combinationally. A message's last word passes the input register and the
// queue, then loads the result register, from which its checksum is shown.
// The result register lets input words keep flowing while a finished
// checksum waits; input stalls only once the two-entry queue and the
// input register are full behind a stalled result.
// ----------------------------------------------------------------------------
module crc32c_checksum
	import crc32c_pkg::*;
#(
	parameter int BYTES_PER_WORD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_word,
	input  logic        last_word,
	output logic        checksum_valid,
	input  logic        checksum_stall,
	output logic [31:0] checksum
);

	// Front end to queue.
	logic      push_valid;
	logic      push_stall;
	crc_item_t push_item;

	// Queue to back end.
	logic      pop_valid;
	logic      pop_stall;
	crc_item_t pop_item;

	// Classify the word: saturate the count, fold the data bytes alone.
	crc32c_front #(
		.BYTES_PER_WORD(BYTES_PER_WORD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.data_word  (data_word),
		.byte_count (byte_count),
		.first_word (first_word),
		.last_word  (last_word),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item)
	);

	// Decouple the two ends so each can stall on its own.
	crc32c_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_item   (pop_item)
	);

	// Hold the running remainder and drive the result register.
	crc32c_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_stall      (pop_stall),
		.pop_item       (pop_item),
		.checksum_valid (checksum_valid),
		.checksum_stall (checksum_stall),
		.checksum       (checksum)
	);

endmodule

// ----- rtl/crc32c_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32c_chk: port-level checks for the CRC-32C checksum block
// Tracks messages closed at the input but not yet delivered, and checks the
// result channel against that count.
// ----------------------------------------------------------------------------
module crc32c_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        word_valid,
	input logic        word_stall,
	input logic        last_word,
	input logic        checksum_valid,
	input logic        checksum_stall,
	input logic [31:0] checksum
);

	// Input register, two queue entries and the result register.
	localparam logic [3:0] MAX_PENDING = 4'd4;

	logic [3:0] pending_q;
	logic       last_in;
	logic       sum_out;

	assign last_in = word_valid && !word_stall && last_word;
	assign sum_out = checksum_valid && !checksum_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else if (last_in && !sum_out) begin
			pending_q <= pending_q + 4'd1;
		end else if (sum_out && !last_in) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	// Hold a stalled checksum valid.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		checksum_valid && checksum_stall |=> checksum_valid)
		else $error("checksum_valid dropped while stalled");

	// Hold a stalled checksum value.
	a_value_holds: assert property (@(posedge clk) disable iff (!arst_n)
		checksum_valid && checksum_stall |=> $stable(checksum))
		else $error("checksum changed while stalled");

	// Drop no message into a result that was never asked for.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		checksum_valid |-> pending_q != 4'd0)
		else $error("checksum without a closed message");

	// Bound closed but undelivered messages by the storage inside the block.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MAX_PENDING)
		else $error("more closed messages in flight than the block can hold");

endmodule

bind crc32c_checksum crc32c_chk u_chk (.*);
